// ===== hdl/rgb_to_packed_bitmap_converter_top_macros.svh =====
// Assertion macros for the RGB to packed bitmap converter.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef RGB_TO_PACKED_BITMAP_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_PACKED_BITMAP_CONVERTER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RPBC_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");
`define RPBC_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("next cycle check failed");
`else
`define RPBC_ASSERT_IMPL(lbl, a, b)
`define RPBC_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ===== hdl/rpbc_pkg.sv =====
// Shared types, codes and the palette ROM of the bitmap converter.
// No dependencies.
package rpbc_pkg;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int PALETTE_ENTRIES = 256;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [2:0] DEPTH_1BPP  = 3'd0;
  localparam logic [2:0] DEPTH_2BPP  = 3'd1;
  localparam logic [2:0] DEPTH_4BPP  = 3'd2;
  localparam logic [2:0] DEPTH_8BPP  = 3'd3;
  localparam logic [2:0] DEPTH_16BPP = 3'd4;

  localparam logic [1:0] CFG_DEPTH_MODE = 2'd0;
  localparam logic [1:0] CFG_ROW_WIDTH  = 2'd1;

  localparam logic [2:0]  DEPTH_RESET = DEPTH_1BPP;
  localparam logic [10:0] WIDTH_RESET = 11'd22;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       row_end;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
    logic       lookup;
    logic       last;
    pixel_t     pixel;
  } cmd_t;

  typedef logic [PALETTE_ENTRIES-1:0][23:0] pal_rom_t;

  function automatic logic [23:0] extra_colour(int k);
    logic [23:0] c;
    case (k)
      0:  c = {8'd17, 8'd17, 8'd17};
      1:  c = {8'd34, 8'd34, 8'd34};
      2:  c = {8'd68, 8'd68, 8'd68};
      3:  c = {8'd85, 8'd85, 8'd85};
      4:  c = {8'd119, 8'd119, 8'd119};
      5:  c = {8'd136, 8'd136, 8'd136};
      6:  c = {8'd170, 8'd170, 8'd170};
      7:  c = {8'd187, 8'd187, 8'd187};
      8:  c = {8'd221, 8'd221, 8'd221};
      9:  c = {8'd238, 8'd238, 8'd238};
      10: c = {8'd192, 8'd192, 8'd192};
      11: c = {8'd128, 8'd0, 8'd0};
      12: c = {8'd128, 8'd0, 8'd128};
      13: c = {8'd0, 8'd128, 8'd0};
      14: c = {8'd0, 8'd128, 8'd128};
      default: c = 24'd0;
    endcase
    return c;
  endfunction

  function automatic pal_rom_t build_palette();
    pal_rom_t rom;
    int j;
    int half;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      if (i < 215) begin
        half = i / 108;
        j = i % 108;
        r = 8'(255 - 51 * (j / 18));
        g = 8'(255 - 51 * (j % 6));
        b = 8'(((half != 0) ? 102 : 255) - 51 * ((j % 18) / 6));
        rom[i] = {r, g, b};
      end else if (i < 230) begin
        rom[i] = extra_colour(i - 215);
      end else begin
        rom[i] = 24'd0;
      end
    end
    return rom;
  endfunction

  localparam pal_rom_t PALETTE_ROM = build_palette();

  function automatic logic [3:0] level_4bpp(logic [9:0] s);
    logic [3:0] lv;
    lv = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (s >= 10'((765 * k + 15) / 16)) lv = lv + 4'd1;
    end
    return lv;
  endfunction

  function automatic logic [3:0] level_2bpp(logic [9:0] s);
    logic [3:0] lv;
    lv = 4'd0;
    for (int k = 1; k < 4; k++) begin
      if (s >= 10'((765 * k + 3) / 4)) lv = lv + 4'd1;
    end
    return lv;
  endfunction
endpackage

// ===== hdl/rpbc_fifo.sv =====
// Small register queue used between the converter's parts.
// No package dependencies.
module rpbc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] head
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    if (do_pop) rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= push_data;
  end
endmodule

// ===== hdl/rpbc_front.sv =====
// Front part: configuration registers, pixel classification and bit packing.
// Depends on rpbc_pkg.
module rpbc_front #(
  parameter int MAX_WIDTH = rpbc_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  rpbc_pkg::pixel_t in_pixel,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [10:0]     cfg_data,
  output logic            cmd_push,
  input  logic            cmd_full,
  output rpbc_pkg::cmd_t  cmd_data
);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > 11) ? CW : 11;

  logic [2:0]    depth_r, depth_nxt;
  logic [10:0]   width_r, width_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [7:0]    acc_r, acc_nxt;
  logic [2:0]    fill_r, fill_nxt;

  logic [WW-1:0] w_raw, w_eff;
  logic [WW:0]   rsum;
  logic          last, odd_row, accept, cfg_wr, white, is_sub;
  logic [9:0]    s;
  logic [3:0]    bpp4, val, fill4, shamt;
  logic [7:0]    a, b0, b1;
  logic [1:0]    n;
  logic [15:0]   rgb565;

  assign cfg_ready = 1'b1;
  assign in_full   = cmd_full;
  assign accept    = in_push && !cmd_full;
  assign cfg_wr    = cfg_valid;

  always_comb begin
    w_raw = WW'(width_r);
    if (w_raw == '0) w_eff = WW'(1);
    else if (w_raw > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = w_raw;
    last = (WW'(col_r) + WW'(1) >= w_eff);
    s = 10'(in_pixel.red) + 10'(in_pixel.green) + 10'(in_pixel.blue);
    white = (in_pixel.red == 8'hFF) && (in_pixel.green == 8'hFF) && (in_pixel.blue == 8'hFF);
    rgb565 = {in_pixel.red[7:3], in_pixel.green[7:2], in_pixel.blue[7:3]};
    unique case (depth_r)
      rpbc_pkg::DEPTH_2BPP: begin
        bpp4 = 4'd2; val = rpbc_pkg::level_2bpp(s); is_sub = 1'b1;
        rsum = {1'b0, w_eff} + (WW+1)'(3); odd_row = rsum[2];
      end
      rpbc_pkg::DEPTH_4BPP: begin
        bpp4 = 4'd4; val = rpbc_pkg::level_4bpp(s); is_sub = 1'b1;
        rsum = {1'b0, w_eff} + (WW+1)'(1); odd_row = rsum[1];
      end
      rpbc_pkg::DEPTH_8BPP: begin
        bpp4 = 4'd8; val = 4'd0; is_sub = 1'b0;
        rsum = {1'b0, w_eff}; odd_row = rsum[0];
      end
      rpbc_pkg::DEPTH_16BPP: begin
        bpp4 = 4'd0; val = 4'd0; is_sub = 1'b0;
        rsum = {1'b0, w_eff}; odd_row = 1'b0;
      end
      default: begin
        bpp4 = 4'd1; val = {3'd0, (s <= 10'd382)}; is_sub = 1'b1;
        rsum = {1'b0, w_eff} + (WW+1)'(7); odd_row = rsum[3];
      end
    endcase

    a = acc_r;
    fill4 = {1'b0, fill_r};
    b0 = 8'd0;
    b1 = 8'd0;
    n = 2'd0;
    shamt = 4'd0;
    if (is_sub) begin
      if (fill4 + bpp4 > 4'd8) begin
        a = 8'd0;
        fill4 = 4'd0;
      end
      shamt = 4'd8 - fill4 - bpp4;
      a = a | (8'(val) << shamt);
      fill4 = fill4 + bpp4;
      if (fill4 >= 4'd8) begin
        b0 = a; n = 2'd1; a = 8'd0; fill4 = 4'd0;
      end
      if (last && fill4 != 4'd0) begin
        if (n == 2'd0) b0 = a;
        else b1 = a;
        n = n + 2'd1; a = 8'd0; fill4 = 4'd0;
      end
    end else if (depth_r == rpbc_pkg::DEPTH_8BPP) begin
      b0 = white ? 8'hFF : 8'h00;
      n = 2'd1;
    end else begin
      b0 = rgb565[15:8];
      b1 = rgb565[7:0];
      n = 2'd2;
    end
    if (last && odd_row && n != 2'd2) begin
      if (n == 2'd0) b0 = 8'd0;
      else b1 = 8'd0;
      n = n + 2'd1;
    end

    cmd_data.byte0  = b0;
    cmd_data.byte1  = b1;
    cmd_data.two    = (n == 2'd2);
    cmd_data.lookup = (depth_r == rpbc_pkg::DEPTH_8BPP) && !white;
    cmd_data.last   = last;
    cmd_data.pixel  = in_pixel;
    cmd_push        = accept && (n != 2'd0);

    depth_nxt = depth_r;
    width_nxt = width_r;
    col_nxt   = col_r;
    acc_nxt   = acc_r;
    fill_nxt  = fill_r;
    if (cfg_wr && (cfg_index == rpbc_pkg::CFG_DEPTH_MODE || cfg_index == rpbc_pkg::CFG_ROW_WIDTH)) begin
      if (cfg_index == rpbc_pkg::CFG_DEPTH_MODE) depth_nxt = cfg_data[2:0];
      else width_nxt = cfg_data;
      col_nxt  = '0;
      acc_nxt  = 8'd0;
      fill_nxt = 3'd0;
    end else if (accept) begin
      if (last) begin
        col_nxt  = '0;
        acc_nxt  = 8'd0;
        fill_nxt = 3'd0;
      end else begin
        col_nxt  = col_r + CW'(1);
        acc_nxt  = a;
        fill_nxt = fill4[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= rpbc_pkg::DEPTH_RESET;
      width_r <= rpbc_pkg::WIDTH_RESET;
      col_r   <= '0;
      acc_r   <= 8'd0;
      fill_r  <= 3'd0;
    end else begin
      depth_r <= depth_nxt;
      width_r <= width_nxt;
      col_r   <= col_nxt;
      acc_r   <= acc_nxt;
      fill_r  <= fill_nxt;
    end
  end
endmodule

// ===== hdl/rpbc_back.sv =====
// Back part: palette search over the ROM and byte emission.
// Depends on rpbc_pkg.
module rpbc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_empty,
  input  rpbc_pkg::cmd_t   cmd_head,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output rpbc_pkg::result_t res_data
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  rpbc_pkg::cmd_t cmd_r, cmd_nxt;
  logic [7:0]     idx_r, idx_nxt, best_r, best_nxt;
  logic [9:0]     bestd_r, bestd_nxt, l1_d;
  logic           sel_r, sel_nxt, fin;
  logic [23:0]    pe;

  function automatic logic [7:0] absdiff(logic [7:0] x, logic [7:0] y);
    return (x > y) ? x - y : y - x;
  endfunction

  always_comb begin
    pe   = rpbc_pkg::PALETTE_ROM[idx_r];
    l1_d = 10'(absdiff(cmd_r.pixel.red, pe[23:16])) + 10'(absdiff(cmd_r.pixel.green, pe[15:8]))
         + 10'(absdiff(cmd_r.pixel.blue, pe[7:0]));
    fin  = !cmd_r.two || sel_r;
    res_data.out_byte = sel_r ? cmd_r.byte1 : cmd_r.byte0;
    res_data.row_end  = cmd_r.last && fin;
    res_data.run_last = fin;
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    bestd_nxt = bestd_r;
    sel_nxt   = sel_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_head;
          idx_nxt   = 8'd0;
          best_nxt  = 8'd0;
          bestd_nxt = 10'h3FF;
          sel_nxt   = 1'b0;
          state_nxt = cmd_head.lookup ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        if (l1_d < bestd_r) begin
          bestd_nxt = l1_d;
          best_nxt  = idx_r;
        end
        idx_nxt = idx_r + 8'd1;
        if (idx_r == 8'(rpbc_pkg::PALETTE_ENTRIES - 1)) begin
          cmd_nxt.byte0 = (l1_d < bestd_r) ? idx_r : best_r;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (fin) begin
            state_nxt = S_IDLE;
          end else begin
            sel_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    best_r  <= best_nxt;
    bestd_r <= bestd_nxt;
    sel_r   <= sel_nxt;
  end
endmodule

// ===== hdl/rgb_to_packed_bitmap_converter_top.sv =====
// Top level of the RGB to packed bitmap converter.
// Depends on rpbc_pkg, rpbc_front, rpbc_fifo, rpbc_back and the macro header.
//
// Channel  Direction  Handshake          Payload
// in       input      push / full        pixel_t (red, green, blue)
// out      output     pop / empty        result_t (out_byte, row_end, run_last)
// cfg      input      valid / ready      index (2 bits), data (11 bits)
//
// A pixel that does not need the palette holds the back part for a load step, then
// an emit step per byte it causes. At 8 bpp a non-white pixel takes a load step,
// a scan of all 256 palette ROM entries, one entry per cycle, and an emit step per byte.
// Reset is synchronous and empties both queues. The front stalls only when the
// command queue is full.
`include "rgb_to_packed_bitmap_converter_top_macros.svh"
module rgb_to_packed_bitmap_converter_top #(
  parameter int MAX_WIDTH = rpbc_pkg::MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  rpbc_pkg::pixel_t  in_pixel,
  output logic              out_empty,
  input  logic              out_pop,
  output rpbc_pkg::result_t out_result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [10:0]       cfg_data
);
  localparam int CMD_W = $bits(rpbc_pkg::cmd_t);
  localparam int RES_W = $bits(rpbc_pkg::result_t);

  logic           cmd_push, cmd_full, cmd_pop, cmd_empty, res_push, res_full;
  rpbc_pkg::cmd_t cmd_in, cmd_head;
  rpbc_pkg::result_t res_in;

  rpbc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_pixel(in_pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd_push(cmd_push), .cmd_full(cmd_full), .cmd_data(cmd_in)
  );

  rpbc_fifo #(.W(CMD_W), .DEPTH(rpbc_pkg::QUEUE_DEPTH)) u_cmd_q (
    .clk(clk), .rst_n(rst_n), .push(cmd_push), .push_data(cmd_in), .full(cmd_full),
    .pop(cmd_pop), .empty(cmd_empty), .head(cmd_head)
  );

  rpbc_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_empty(cmd_empty), .cmd_head(cmd_head), .cmd_pop(cmd_pop),
    .res_full(res_full), .res_push(res_push), .res_data(res_in)
  );

  rpbc_fifo #(.W(RES_W), .DEPTH(rpbc_pkg::QUEUE_DEPTH)) u_res_q (
    .clk(clk), .rst_n(rst_n), .push(res_push), .push_data(res_in), .full(res_full),
    .pop(out_pop), .empty(out_empty), .head(out_result)
  );

  `RPBC_ASSERT_NEXT(a_reset_empty, !rst_n, out_empty && !in_full)
  `RPBC_ASSERT_IMPL(a_row_end_last, !out_empty && out_result.row_end, out_result.run_last)
  `RPBC_ASSERT_IMPL(a_pop_has_cmd, cmd_pop, !cmd_empty)
endmodule
